@@ hdl/poi_pkg.sv @@
package poi_pkg;

  // Field widths of one sample and one result
  localparam int unsigned VelW  = 16;
  localparam int unsigned YawW  = 24;
  localparam int unsigned DtW   = 20;
  localparam int unsigned CovW  = 16;
  localparam int unsigned PosW  = 48;
  localparam int unsigned AngW  = 36;
  localparam int unsigned VarW  = 48;

  // Quarter-wave sine table construction (Q30 Taylor series, Q16 entries)
  localparam logic [63:0] PiHalfQ30 = 64'd1686629713;
  localparam int unsigned TaylorFrac = 30;
  localparam int unsigned SinShift   = 14;
  localparam logic [63:0] SinRound   = 64'd8192;
  localparam logic [63:0] SinOne     = 64'd65536;

  typedef struct packed {
    logic signed [VelW-1:0] vel_x;
    logic signed [VelW-1:0] vel_y;
    logic signed [YawW-1:0] yaw_rate;
    logic [DtW-1:0]         step_time;
    logic [CovW-1:0]        cov_x;
    logic [CovW-1:0]        cov_y;
    logic [CovW-1:0]        cov_z;
    logic [CovW-1:0]        cov_yaw;
    logic                   last;
  } poi_in_t;

  typedef struct packed {
    logic signed [PosW-1:0] disp_x;
    logic signed [PosW-1:0] disp_y;
    logic [AngW-1:0]        heading;
    logic [VarW-1:0]        sum_var_x;
    logic [VarW-1:0]        sum_var_y;
    logic [VarW-1:0]        sum_var_z;
    logic [VarW-1:0]        sum_var_heading;
    logic [VarW-1:0]        tilt_sigma;
  } poi_out_t;

endpackage

@@ hdl/planar_odometry_integrator.sv @@
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o   | poi_pkg::poi_in_t  (one odometry sample)
// out     | output    | out_valid_o / out_stall_i | poi_pkg::poi_out_t (relative pose, sums)
//
// A sample holds the block from its accept edge to the next possible accept, and
// longer when it is marked last: one shared 36x21 signed multiplier forms all
// eleven products of a sample, one per cycle, under a step sequencer.
// Reset clears the accumulators, the sequencer and the output valid; the sine table
// is a constant ROM and needs no fill.
// A last sample waits in its emit step while an earlier result is still stalled.
module planar_odometry_integrator #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  poi_pkg::poi_in_t    in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output poi_pkg::poi_out_t   out_data_o
);

  localparam int unsigned IdxW  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned FracW = poi_pkg::AngW - 2;
  localparam int unsigned ProdW = FracW + IdxW;
  localparam int unsigned TrigW = 18;
  localparam int unsigned MulAW = 36;
  localparam int unsigned MulBW = 21;
  localparam int unsigned PW    = 53;
  localparam int unsigned RotW  = 54;
  localparam int unsigned RndW  = RotW + 1 - 16;

  // Sequencer steps
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_LOOKUP   = 4'd1;
  localparam logic [3:0] ST_MUL_DY   = 4'd2;
  localparam logic [3:0] ST_XC       = 4'd3;
  localparam logic [3:0] ST_YS       = 4'd4;
  localparam logic [3:0] ST_XS       = 4'd5;
  localparam logic [3:0] ST_YC       = 4'd6;
  localparam logic [3:0] ST_HEAD     = 4'd7;
  localparam logic [3:0] ST_VARX     = 4'd8;
  localparam logic [3:0] ST_VARY     = 4'd9;
  localparam logic [3:0] ST_VARZ     = 4'd10;
  localparam logic [3:0] ST_VARH     = 4'd11;
  localparam logic [3:0] ST_VARH_ACC = 4'd12;
  localparam logic [3:0] ST_EMIT     = 4'd13;

  // Heading quadrants
  localparam logic [1:0] QUAD_FIRST  = 2'd0;
  localparam logic [1:0] QUAD_SECOND = 2'd1;
  localparam logic [1:0] QUAD_THIRD  = 2'd2;

  function automatic logic [63:0] taylor_next(input logic [63:0] t, input logic [63:0] x);
    logic [63:0] a;
    a = (t * x) >> poi_pkg::TaylorFrac;
    return (a * x) >> poi_pkg::TaylorFrac;
  endfunction

  // One quarter-wave entry: odd Taylor terms to x^17 in Q30, rounded to Q16
  function automatic logic [16:0] sin_entry(input int unsigned i);
    logic [63:0]        x;
    logic [63:0]        t;
    logic signed [63:0] s;
    logic [63:0]        r;
    x = (poi_pkg::PiHalfQ30 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
    t = x;
    s = $signed(x);
    t = taylor_next(t, x) / 64'd6;   s = s - $signed(t);
    t = taylor_next(t, x) / 64'd20;  s = s + $signed(t);
    t = taylor_next(t, x) / 64'd42;  s = s - $signed(t);
    t = taylor_next(t, x) / 64'd72;  s = s + $signed(t);
    t = taylor_next(t, x) / 64'd110; s = s - $signed(t);
    t = taylor_next(t, x) / 64'd156; s = s + $signed(t);
    t = taylor_next(t, x) / 64'd210; s = s - $signed(t);
    t = taylor_next(t, x) / 64'd272; s = s + $signed(t);
    if (s < 0) begin
      r = 64'd0;
    end else begin
      r = ($unsigned(s) + poi_pkg::SinRound) >> poi_pkg::SinShift;
    end
    if (r > poi_pkg::SinOne) begin
      r = poi_pkg::SinOne;
    end
    return r[16:0];
  endfunction

  // Quarter-wave sine ROM, built at elaboration
  logic [16:0] sin_rom [SINE_TABLE_DEPTH+1];

  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [16:0] Entry = sin_entry(g);
    assign sin_rom[g] = Entry;
  end

  logic [3:0] state_q, state_d;
  poi_pkg::poi_in_t in_q;

  logic signed [poi_pkg::PosW-1:0] acc_x_q, acc_y_q;
  logic [poi_pkg::AngW-1:0]        acc_heading_q;
  logic [poi_pkg::VarW-1:0]        acc_var_x_q, acc_var_y_q, acc_var_z_q, acc_var_h_q;

  logic [16:0]              s0_q, c0_q;
  logic signed [TrigW-1:0]  sn_q, cs_q;
  logic signed [MulAW-1:0]  dx_q, dy_q;
  logic signed [PW-1:0]     p_q;
  logic signed [RotW-1:0]   rot_q;
  logic signed [RndW-1:0]   rnd_q;

  logic                     out_valid_q;
  poi_pkg::poi_out_t        out_q;

  logic                     accept;
  logic                     emit_fire;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Table addresses from the heading held before this sample
  logic [ProdW-1:0] idx_prod;
  logic [IdxW-1:0]  sin_idx, cos_idx;

  assign idx_prod = ProdW'(acc_heading_q[FracW-1:0]) * ProdW'(SINE_TABLE_DEPTH);
  assign sin_idx  = idx_prod[ProdW-1:FracW];
  assign cos_idx  = IdxW'(SINE_TABLE_DEPTH) - sin_idx;

  // Apply quadrant signs and swaps
  logic signed [TrigW-1:0] s0_ext, c0_ext, sn_d, cs_d;

  assign s0_ext = $signed({1'b0, s0_q});
  assign c0_ext = $signed({1'b0, c0_q});

  always_comb begin
    case (acc_heading_q[poi_pkg::AngW-1:FracW])
      QUAD_FIRST: begin
        sn_d = s0_ext;
        cs_d = c0_ext;
      end
      QUAD_SECOND: begin
        sn_d = c0_ext;
        cs_d = -s0_ext;
      end
      QUAD_THIRD: begin
        sn_d = -s0_ext;
        cs_d = -c0_ext;
      end
      default: begin
        sn_d = -c0_ext;
        cs_d = s0_ext;
      end
    endcase
  end

  // Shared multiplier operand select
  logic signed [MulAW-1:0]       mul_a;
  logic signed [MulBW-1:0]       mul_b;
  logic signed [MulAW+MulBW-1:0] mul_p;
  logic signed [MulBW-1:0]       dt_s;

  assign dt_s = $signed({1'b0, in_q.step_time});

  always_comb begin
    case (state_q)
      ST_LOOKUP: begin
        mul_a = MulAW'(in_q.vel_x);
        mul_b = dt_s;
      end
      ST_MUL_DY: begin
        mul_a = MulAW'(in_q.vel_y);
        mul_b = dt_s;
      end
      ST_XC: begin
        mul_a = dx_q;
        mul_b = MulBW'(cs_q);
      end
      ST_YS: begin
        mul_a = dy_q;
        mul_b = MulBW'(sn_q);
      end
      ST_XS: begin
        mul_a = dx_q;
        mul_b = MulBW'(sn_q);
      end
      ST_YC: begin
        mul_a = dy_q;
        mul_b = MulBW'(cs_q);
      end
      ST_HEAD: begin
        mul_a = MulAW'(in_q.yaw_rate);
        mul_b = dt_s;
      end
      ST_VARX: begin
        mul_a = $signed({20'd0, in_q.cov_x});
        mul_b = dt_s;
      end
      ST_VARY: begin
        mul_a = $signed({20'd0, in_q.cov_y});
        mul_b = dt_s;
      end
      ST_VARZ: begin
        mul_a = $signed({20'd0, in_q.cov_z});
        mul_b = dt_s;
      end
      ST_VARH: begin
        mul_a = $signed({20'd0, in_q.cov_yaw});
        mul_b = dt_s;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Round the rotated sum to nearest, ties away from zero
  logic signed [RotW:0]   rnd_sum;
  logic signed [RotW:0]   rnd_bias;

  assign rnd_bias = rot_q[RotW-1] ? (RotW+1)'(32767) : (RotW+1)'(32768);
  assign rnd_sum  = (RotW+1)'(rot_q) + rnd_bias;

  // Position add with saturation, shared by x and y
  logic signed [poi_pkg::PosW-1:0] pos_sel, pos_new;
  logic signed [poi_pkg::PosW:0]   pos_sum;

  assign pos_sel = (state_q == ST_HEAD) ? acc_x_q : acc_y_q;
  assign pos_sum = (poi_pkg::PosW+1)'(pos_sel) + (poi_pkg::PosW+1)'(rnd_q);

  always_comb begin
    if (pos_sum[poi_pkg::PosW] != pos_sum[poi_pkg::PosW-1]) begin
      pos_new = pos_sum[poi_pkg::PosW] ? {1'b1, {(poi_pkg::PosW-1){1'b0}}}
                                       : {1'b0, {(poi_pkg::PosW-1){1'b1}}};
    end else begin
      pos_new = pos_sum[poi_pkg::PosW-1:0];
    end
  end

  // Variance add with saturation, shared by all four sums
  logic [poi_pkg::VarW-1:0] var_sel, var_new;
  logic [poi_pkg::VarW:0]   var_sum;

  always_comb begin
    case (state_q)
      ST_VARY:     var_sel = acc_var_x_q;
      ST_VARZ:     var_sel = acc_var_y_q;
      ST_VARH:     var_sel = acc_var_z_q;
      ST_VARH_ACC: var_sel = acc_var_h_q;
      default:     var_sel = acc_var_x_q;
    endcase
  end

  assign var_sum = {1'b0, var_sel} + (poi_pkg::VarW+1)'(p_q[poi_pkg::AngW-1:0]);
  assign var_new = var_sum[poi_pkg::VarW] ? '1 : var_sum[poi_pkg::VarW-1:0];

  // Tilt sigma is twice the heading variance, saturated
  logic [poi_pkg::VarW-1:0] tilt;

  assign tilt = acc_var_h_q[poi_pkg::VarW-1] ? '1 : {acc_var_h_q[poi_pkg::VarW-2:0], 1'b0};

  // Advance the sequencer
  always_comb begin
    case (state_q)
      ST_IDLE:     state_d = accept ? ST_LOOKUP : ST_IDLE;
      ST_LOOKUP:   state_d = ST_MUL_DY;
      ST_MUL_DY:   state_d = ST_XC;
      ST_XC:       state_d = ST_YS;
      ST_YS:       state_d = ST_XS;
      ST_XS:       state_d = ST_YC;
      ST_YC:       state_d = ST_HEAD;
      ST_HEAD:     state_d = ST_VARX;
      ST_VARX:     state_d = ST_VARY;
      ST_VARY:     state_d = ST_VARZ;
      ST_VARZ:     state_d = ST_VARH;
      ST_VARH:     state_d = ST_VARH_ACC;
      ST_VARH_ACC: state_d = in_q.last ? ST_EMIT : ST_IDLE;
      ST_EMIT:     state_d = emit_fire ? ST_IDLE : ST_EMIT;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Control state and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      acc_x_q       <= '0;
      acc_y_q       <= '0;
      acc_heading_q <= '0;
      acc_var_x_q   <= '0;
      acc_var_y_q   <= '0;
      acc_var_z_q   <= '0;
      acc_var_h_q   <= '0;
    end else begin
      state_q <= state_d;

      // Drop the result once taken, raise it on emit
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_HEAD:     acc_x_q       <= pos_new;
        ST_VARX:     acc_heading_q <= acc_heading_q + p_q[poi_pkg::AngW-1:0];
        ST_VARY: begin
          acc_y_q     <= pos_new;
          acc_var_x_q <= var_new;
        end
        ST_VARZ:     acc_var_y_q   <= var_new;
        ST_VARH:     acc_var_z_q   <= var_new;
        ST_VARH_ACC: acc_var_h_q   <= var_new;
        ST_EMIT: begin
          if (emit_fire) begin
            acc_x_q       <= '0;
            acc_y_q       <= '0;
            acc_heading_q <= '0;
            acc_var_x_q   <= '0;
            acc_var_y_q   <= '0;
            acc_var_z_q   <= '0;
            acc_var_h_q   <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end

    p_q <= mul_p[PW-1:0];

    case (state_q)
      ST_LOOKUP: begin
        s0_q <= sin_rom[sin_idx];
        c0_q <= sin_rom[cos_idx];
      end
      ST_MUL_DY: begin
        dx_q <= p_q[MulAW-1:0];
        sn_q <= sn_d;
        cs_q <= cs_d;
      end
      ST_XC:   dy_q  <= p_q[MulAW-1:0];
      ST_YS:   rot_q <= RotW'(p_q);
      ST_XS:   rot_q <= rot_q - RotW'(p_q);
      ST_YC: begin
        rnd_q <= rnd_sum[RotW:16];
        rot_q <= RotW'(p_q);
      end
      ST_HEAD: rot_q <= rot_q + RotW'(p_q);
      ST_VARX: rnd_q <= rnd_sum[RotW:16];
      default: begin
      end
    endcase

    // Load the result on emit
    if (emit_fire) begin
      out_q.disp_x          <= acc_x_q;
      out_q.disp_y          <= acc_y_q;
      out_q.heading         <= acc_heading_q;
      out_q.sum_var_x       <= acc_var_x_q;
      out_q.sum_var_y       <= acc_var_y_q;
      out_q.sum_var_z       <= acc_var_z_q;
      out_q.sum_var_heading <= acc_var_h_q;
      out_q.tilt_sigma      <= tilt;
    end
  end

endmodule

@@ hdl/poi_checker.sv @@
module poi_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input poi_pkg::poi_out_t out_data_o
);

  logic in_beat;

  assign in_beat = in_valid_i && !in_stall_o;

  // Hold off the next beat while the sequencer works on this one
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> in_stall_o ##1 in_stall_o)
    else $error("input taken again while a sample is still in progress");

  // Raise a result only out of a busy sequencer
  a_emit_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result raised while the block was idle");

  // Tilt sigma follows the heading variance sum
  a_tilt_sigma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.sum_var_heading[47] && (out_data_o.tilt_sigma == 48'hFFFF_FFFF_FFFF)) ||
      (!out_data_o.sum_var_heading[47] &&
       (out_data_o.tilt_sigma == {out_data_o.sum_var_heading[46:0], 1'b0})))
    else $error("tilt sigma disagrees with heading variance sum");

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed or dropped");

endmodule

bind planar_odometry_integrator poi_checker u_poi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
